### design/line_correlator_with_border_modes_assert.svh
// Assertion macros used by the line correlator window module.
`ifndef LINE_CORRELATOR_WITH_BORDER_MODES_ASSERT_SVH
`define LINE_CORRELATOR_WITH_BORDER_MODES_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LCB_ASSERT_IMP(label, c, rn, ante, cons, msg) \
	label: assert property (@(posedge c) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LCB_ASSERT_NXT(label, c, rn, ante, cons, msg) \
	label: assert property (@(posedge c) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/lcb_pkg.sv
// Shared types and constants of the line correlator.
package lcb_pkg;

	localparam int DEF_MAX_RADIUS = 7;
	localparam int DEF_MAX_LINE   = 4096;

	localparam int SAMPLE_W      = 16;
	localparam int TAP_W         = 16;
	localparam int OUT_W         = 24;
	localparam int CFG_DATA_W    = 64;
	localparam int CFG_IDX_W     = 3;
	localparam int RADIUS_W      = 3;
	localparam int FILL_W        = 16;
	localparam int NUM_TAP_WORDS = 4;
	localparam int TAPS_PER_WORD = 4;
	localparam int NUM_TAP_REGS  = 15;
	localparam int FRAC_BITS     = 14;
	localparam int PROD_W        = 32;
	localparam int GRP_SIZE      = 4;

	typedef enum logic [1:0] {
		BORDER_CONSTANT  = 2'd0,
		BORDER_REPLICATE = 2'd1,
		BORDER_REFLECT   = 2'd2,
		BORDER_REFL_101  = 2'd3
	} border_mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TAP_WORD_0 = 3'd0,
		REG_TAP_WORD_1 = 3'd1,
		REG_TAP_WORD_2 = 3'd2,
		REG_TAP_WORD_3 = 3'd3,
		REG_RADIUS     = 3'd4,
		REG_BORDER     = 3'd5,
		REG_FILL       = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic [RADIUS_W-1:0]      radius;
		border_mode_t             mode;
		logic signed [FILL_W-1:0] fill;
	} lcb_cfg_t;

	typedef struct packed {
		logic valid;
		logic eol;
	} job_ctl_t;

endpackage

### design/lcb_if.sv
// Stream interfaces for line samples and filtered results.
interface lcb_in_if import lcb_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       last_in_line;

	modport source (output valid, output sample, output last_in_line, input ready);
	modport sink (input valid, input sample, input last_in_line, output ready);
endinterface

interface lcb_out_if import lcb_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [OUT_W-1:0] filtered_value;
	logic                    saturated;
	logic                    end_of_line;

	modport source (output valid, output filtered_value, output saturated,
		output end_of_line, input ready);
	modport sink (input valid, input filtered_value, input saturated,
		input end_of_line, output ready);
endinterface

### design/lcb_window.sv
// Sample window, line head store, result sequencer and border-extended tap gather.
`include "line_correlator_with_border_modes_assert.svh"

module lcb_window import lcb_pkg::*; #(
	parameter int MAX_RADIUS = DEF_MAX_RADIUS,
	parameter int MAX_LINE   = DEF_MAX_LINE,
	parameter int NLANES     = 2 * MAX_RADIUS + 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	lcb_in_if.sink                     samples,
	input  lcb_cfg_t                   cfg,
	input  logic                       adv,
	output job_ctl_t                   job_s1,
	output logic signed [SAMPLE_W-1:0] job_val_s1 [NLANES]
);

	localparam int WIN_DEPTH  = NLANES;
	localparam int HEAD_DEPTH = MAX_RADIUS + 1;
	localparam int PW         = $clog2(MAX_LINE + 1);
	localparam int IW         = PW + 2;
	localparam int WIX_W      = $clog2(WIN_DEPTH);
	localparam int HIX_W      = $clog2(HEAD_DEPTH);

	localparam logic signed [IW-1:0] ZERO_S   = '0;
	localparam logic signed [IW-1:0] ONE_S    = IW'(1);
	localparam logic signed [IW-1:0] WIN_LIM  = IW'(WIN_DEPTH);
	localparam logic signed [IW-1:0] HEAD_LIM = IW'(HEAD_DEPTH);
	localparam logic [PW-1:0]        POS_MAX  = PW'(MAX_LINE);

	logic signed [SAMPLE_W-1:0] win_q  [WIN_DEPTH];
	logic signed [SAMPLE_W-1:0] head_q [HEAD_DEPTH];
	logic [PW-1:0]              pos_q;

	logic          gen_valid_q;
	logic          gen_last_q;
	logic [PW-1:0] gen_pos_q;
	logic [PW-1:0] gen_cur_q;

	logic [RADIUS_W-1:0]        r_eff;
	logic [PW-1:0]              r_ext;
	logic                       acc;
	logic                       flush_more;
	logic signed [IW-1:0]       cur_s;
	logic signed [IW-1:0]       two_cur;
	logic signed [SAMPLE_W-1:0] gath [NLANES];

	// Radius in use, limited to what the window can hold.
	assign r_eff = (cfg.radius > MAX_RADIUS) ? RADIUS_W'(MAX_RADIUS) : cfg.radius;
	assign r_ext = PW'(r_eff);

	// A last sample issues several results; the input waits until the final one goes.
	assign flush_more    = gen_valid_q && gen_last_q && (gen_pos_q != gen_cur_q);
	assign samples.ready = adv && !flush_more;
	assign acc           = samples.valid && samples.ready;

	// Window shift, line head capture and line position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WIN_DEPTH; i++) win_q[i] <= '0;
			for (int i = 0; i < HEAD_DEPTH; i++) head_q[i] <= '0;
			pos_q <= '0;
		end else if (acc) begin
			for (int i = WIN_DEPTH - 1; i > 0; i--) win_q[i] <= win_q[i-1];
			win_q[0] <= samples.sample;
			if (pos_q < PW'(HEAD_DEPTH)) head_q[pos_q[HIX_W-1:0]] <= samples.sample;
			if (samples.last_in_line) begin
				pos_q <= '0;
			end else if (pos_q < POS_MAX) begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

	// Result sequencer: which line position is gathered next.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_valid_q <= 1'b0;
			gen_last_q  <= 1'b0;
			gen_pos_q   <= '0;
			gen_cur_q   <= '0;
		end else if (acc) begin
			gen_cur_q  <= pos_q;
			gen_last_q <= samples.last_in_line;
			if (samples.last_in_line) begin
				gen_valid_q <= 1'b1;
				gen_pos_q   <= (pos_q > r_ext) ? pos_q - r_ext : '0;
			end else begin
				gen_valid_q <= (pos_q >= r_ext);
				gen_pos_q   <= pos_q - r_ext;
			end
		end else if (adv && gen_valid_q) begin
			if (flush_more) begin
				gen_pos_q <= gen_pos_q + 1'b1;
			end else begin
				gen_valid_q <= 1'b0;
			end
		end
	end

	assign cur_s   = $signed(IW'(gen_cur_q));
	assign two_cur = cur_s <<< 1;

	// Per-lane sample fetch with border extension.
	for (genvar k = 0; k < NLANES; k++) begin : g_lane
		logic signed [IW-1:0] idx;
		logic signed [IW-1:0] ridx;
		logic signed [IW-1:0] cidx;
		logic signed [IW-1:0] age;
		logic                 outside;
		logic                 lane_on;

		always_comb begin
			idx     = $signed(IW'(gen_pos_q)) - $signed(IW'(r_eff)) + IW'(k);
			outside = (idx < ZERO_S) || (gen_last_q && (idx > cur_s));
			lane_on = (k <= 2 * int'(r_eff));

			case (cfg.mode)
				BORDER_REPLICATE: ridx = (idx < ZERO_S) ? ZERO_S : cur_s;
				BORDER_REFLECT:   ridx = (idx < ZERO_S) ? -idx - ONE_S : two_cur + ONE_S - idx;
				BORDER_REFL_101:  ridx = (idx < ZERO_S) ? -idx : two_cur - idx;
				default:          ridx = idx;
			endcase

			// A reflection on a short line may still land outside; clamp it in.
			if (!outside) begin
				cidx = idx;
			end else if (ridx < ZERO_S) begin
				cidx = ZERO_S;
			end else if (ridx > cur_s) begin
				cidx = cur_s;
			end else begin
				cidx = ridx;
			end
			age = cur_s - cidx;

			if (!lane_on) begin
				gath[k] = '0;
			end else if (outside && (cfg.mode == BORDER_CONSTANT)) begin
				gath[k] = cfg.fill;
			end else if ((age >= ZERO_S) && (age < WIN_LIM)) begin
				gath[k] = win_q[age[WIX_W-1:0]];
			end else if ((cidx >= ZERO_S) && (cidx < HEAD_LIM)) begin
				gath[k] = head_q[cidx[HIX_W-1:0]];
			end else begin
				gath[k] = '0;
			end
		end
	end

	// Gathered request register, control part.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_s1 <= '0;
		end else if (adv) begin
			job_s1.valid <= gen_valid_q;
			job_s1.eol   <= gen_last_q && (gen_pos_q == gen_cur_q);
		end
	end

	// Gathered request register, sample values.
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < NLANES; i++) job_val_s1[i] <= gath[i];
		end
	end

	`LCB_ASSERT_NXT(a_last_clears_pos, clk, arst_n, acc && samples.last_in_line, pos_q == '0, "line position not cleared after last sample")
	`LCB_ASSERT_IMP(a_gen_in_order, clk, arst_n, gen_valid_q, gen_pos_q <= gen_cur_q, "sequencer ran past the newest sample")
	`LCB_ASSERT_NXT(a_flush_continues, clk, arst_n, flush_more && adv, gen_valid_q && gen_last_q, "line flush ended early")

endmodule

### design/lcb_mac.sv
// Tap multiply, adder tree, rounding, saturation and output register.
module lcb_mac import lcb_pkg::*; #(
	parameter int NLANES = 2 * DEF_MAX_RADIUS + 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  job_ctl_t                   job_s1,
	input  logic signed [SAMPLE_W-1:0] job_val_s1 [NLANES],
	input  logic signed [TAP_W-1:0]    taps [NUM_TAP_REGS],
	lcb_out_if.source                  results,
	output logic                       adv
);

	localparam int NGRP  = (NLANES + GRP_SIZE - 1) / GRP_SIZE;
	localparam int GRP_W = PROD_W + $clog2(GRP_SIZE);
	localparam int SUM_W = GRP_W + $clog2(NGRP) + 1;

	localparam logic signed [SUM_W-1:0] ROUND_BIAS = SUM_W'(1) <<< (FRAC_BITS - 1);
	localparam logic signed [SUM_W-1:0] SAT_HI     = SUM_W'((1 << (OUT_W - 1)) - 1);
	localparam logic signed [SUM_W-1:0] SAT_LO     = ~SAT_HI;

	job_ctl_t                 ctl_s2, ctl_s3, ctl_s4;
	logic signed [PROD_W-1:0] prod_s2 [NLANES];
	logic signed [GRP_W-1:0]  grp_d   [NGRP];
	logic signed [GRP_W-1:0]  grp_s3  [NGRP];
	logic signed [OUT_W-1:0]  val_s4;
	logic                     sat_s4;

	logic signed [SUM_W-1:0]  total;
	logic signed [SUM_W-1:0]  shifted;
	logic signed [OUT_W-1:0]  val_d;
	logic                     sat_d;

	// The whole pipeline moves unless a finished result is still waiting.
	assign adv = !ctl_s4.valid || results.ready;

	// Control pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
		end else if (adv) begin
			ctl_s2 <= job_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
		end
	end

	// One product per lane; lanes past the configured taps weigh zero.
	for (genvar k = 0; k < NLANES; k++) begin : g_prod
		if (k < NUM_TAP_REGS) begin : g_tap
			always_ff @(posedge clk) begin
				if (adv) begin
					prod_s2[k] <= $signed(PROD_W'(job_val_s1[k])) * $signed(PROD_W'(taps[k]));
				end
			end
		end else begin : g_zero
			always_ff @(posedge clk) begin
				if (adv) prod_s2[k] <= '0;
			end
		end
	end

	// First adder level: small groups of products.
	for (genvar g = 0; g < NGRP; g++) begin : g_grp
		always_comb begin
			logic signed [GRP_W-1:0] part;
			part = '0;
			for (int j = 0; j < GRP_SIZE; j++) begin
				if (g * GRP_SIZE + j < NLANES) part = part + GRP_W'(prod_s2[g * GRP_SIZE + j]);
			end
			grp_d[g] = part;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int g = 0; g < NGRP; g++) grp_s3[g] <= grp_d[g];
		end
	end

	// Final sum, round half up after the Q2.14 shift, and clip to the output range.
	always_comb begin
		total = '0;
		for (int g = 0; g < NGRP; g++) total = total + SUM_W'(grp_s3[g]);
		shifted = (total + ROUND_BIAS) >>> FRAC_BITS;
		if (shifted > SAT_HI) begin
			val_d = SAT_HI[OUT_W-1:0];
			sat_d = 1'b1;
		end else if (shifted < SAT_LO) begin
			val_d = SAT_LO[OUT_W-1:0];
			sat_d = 1'b1;
		end else begin
			val_d = shifted[OUT_W-1:0];
			sat_d = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			val_s4 <= val_d;
			sat_s4 <= sat_d;
		end
	end

	assign results.valid          = ctl_s4.valid;
	assign results.filtered_value = val_s4;
	assign results.saturated      = sat_s4;
	assign results.end_of_line    = ctl_s4.eol;

endmodule

### design/line_correlator_with_border_modes.sv
// Top level of the line correlator: configuration registers and datapath.
//
// Filters one image line with a 2R+1 tap correlation, one sample accepted per clock
// unless the output stalls. A result for line position q follows the sample that
// completes it (sample q+R, or the last sample of the line) through the sequencer,
// border gather, multiply, group-add and round/clip registers. The last sample of a
// line releases up to R+1 results, one per clock from the sequencer unless the output
// stalls, and the input is held off until the final one goes; otherwise the rate is
// one item per clock, set by the single sequencer slot. Samples outside the line come
// from the border mode (constant fill, replicate, reflect, reflect-101); lines must be
// longer than R. Change the registers only while the block is idle.
module line_correlator_with_border_modes import lcb_pkg::*; #(
	parameter int MAX_RADIUS = DEF_MAX_RADIUS,
	parameter int MAX_LINE   = DEF_MAX_LINE
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	lcb_in_if.sink                samples,
	lcb_out_if.source             results
);

	localparam int NLANES = 2 * MAX_RADIUS + 1;

	logic [CFG_DATA_W-1:0]      tap_word_q [NUM_TAP_WORDS];
	logic [RADIUS_W-1:0]        radius_q;
	border_mode_t               mode_q;
	logic signed [FILL_W-1:0]   fill_q;

	lcb_cfg_t                   cfg;
	logic signed [TAP_W-1:0]    taps [NUM_TAP_REGS];
	job_ctl_t                   job_s1;
	logic signed [SAMPLE_W-1:0] job_val_s1 [NLANES];
	logic                       adv;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_TAP_WORDS; i++) tap_word_q[i] <= '0;
			radius_q <= RADIUS_W'(1);
			mode_q   <= BORDER_CONSTANT;
			fill_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_TAP_WORD_0: tap_word_q[0] <= cfg_data;
				REG_TAP_WORD_1: tap_word_q[1] <= cfg_data;
				REG_TAP_WORD_2: tap_word_q[2] <= cfg_data;
				REG_TAP_WORD_3: tap_word_q[3] <= cfg_data;
				REG_RADIUS:     radius_q <= cfg_data[RADIUS_W-1:0];
				REG_BORDER:     mode_q <= border_mode_t'(cfg_data[1:0]);
				REG_FILL:       fill_q <= $signed(cfg_data[FILL_W-1:0]);
				default: ;
			endcase
		end
	end

	assign cfg.radius = radius_q;
	assign cfg.mode   = mode_q;
	assign cfg.fill   = fill_q;

	// Unpack the tap words, lowest tap in the low bits of each word.
	for (genvar k = 0; k < NUM_TAP_REGS; k++) begin : g_taps
		assign taps[k] = $signed(tap_word_q[k / TAPS_PER_WORD][TAP_W * (k % TAPS_PER_WORD) +: TAP_W]);
	end

	lcb_window #(
		.MAX_RADIUS (MAX_RADIUS),
		.MAX_LINE   (MAX_LINE),
		.NLANES     (NLANES)
	) u_window (
		.clk        (clk),
		.arst_n     (arst_n),
		.samples    (samples),
		.cfg        (cfg),
		.adv        (adv),
		.job_s1     (job_s1),
		.job_val_s1 (job_val_s1)
	);

	lcb_mac #(
		.NLANES (NLANES)
	) u_mac (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_s1     (job_s1),
		.job_val_s1 (job_val_s1),
		.taps       (taps),
		.results    (results),
		.adv        (adv)
	);

endmodule

### verif/testbench.sv
`timescale 1ns / 100ps
// Self-checking stream testbench of the line correlator with border modes.
module testbench;
	import lcb_pkg::*;

	localparam int CYCLE_LIMIT   = 800000;
	localparam int SETTLE_CYCLES = 12;
	localparam int HOLD_CYCLES   = 300;
	localparam int RANDOM_PHASES = 12;
	localparam int PHASE_ITEMS   = 34;
	localparam int PRESSURE_PH   = 4;
	localparam int LONG_LINE_LEN = 48;
	localparam int WIN_LEN       = 2 * DEF_MAX_RADIUS + 1;
	localparam int HEAD_LEN      = DEF_MAX_RADIUS + 1;
	localparam int MAX_PRINTS    = 50;

	typedef struct {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       last;
	} line_sample_t;

	typedef struct {
		logic signed [OUT_W-1:0] value;
		logic                    sat;
		logic                    eol;
	} filt_result_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	lcb_in_if  samples_if ();
	lcb_out_if results_if ();

	line_correlator_with_border_modes u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.samples   (samples_if),
		.results   (results_if)
	);

	// Mirror of the configuration registers.
	logic [CFG_DATA_W-1:0]    tap_words [NUM_TAP_WORDS];
	logic [RADIUS_W-1:0]      radius_cfg;
	border_mode_t             border_cfg;
	logic signed [FILL_W-1:0] fill_cfg;

	// Filter state as seen by the predictor.
	logic signed [SAMPLE_W-1:0] recent [WIN_LEN];
	logic signed [SAMPLE_W-1:0] head [HEAD_LEN];
	int                         line_pos;

	line_sample_t pending_samples [$];
	filt_result_t expected_results [$];
	line_sample_t offered;
	bit           offering;
	int           sender_idle_pct;
	int           receiver_idle_pct;
	bit           hold_wanted;
	bit           hold_done;
	int           hold_left;
	int           line_left;
	int           cycle_count;
	int           mismatches;
	int           samples_sent;
	int           results_seen;
	int           lines_sent;
	int           settings_used;

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	task automatic report_mismatch(string what);
		mismatches++;
		if (mismatches <= MAX_PRINTS)
			$display("[%0t] mismatch: %s", $time, what);
	endtask

	// Expected result for line position q, with cur the newest index of the line.
	function automatic void predict_position(int q, int cur, bit last, bit eol);
		int r;
		int idx;
		int age;
		int tap;
		bit outside;
		longint acc;
		longint rounded;
		logic signed [SAMPLE_W-1:0] x;
		filt_result_t res;
		r = int'(radius_cfg);
		acc = 0;
		for (int k = 0; k <= 2 * r; k++) begin
			idx = q - r + k;
			outside = (idx < 0) || (last && idx > cur);
			if (outside && border_cfg == BORDER_CONSTANT) begin
				x = fill_cfg;
			end else begin
				// Remap positions beyond the line ends, then clamp for short lines.
				if (outside) begin
					case (border_cfg)
						BORDER_REPLICATE: idx = (idx < 0) ? 0 : cur;
						BORDER_REFLECT:   idx = (idx < 0) ? -idx - 1 : 2 * cur + 1 - idx;
						default:          idx = (idx < 0) ? -idx : 2 * cur - idx;
					endcase
					if (idx < 0)
						idx = 0;
					if (idx > cur)
						idx = cur;
				end
				age = cur - idx;
				if (age >= 0 && age < WIN_LEN)
					x = recent[age];
				else if (idx >= 0 && idx < HEAD_LEN)
					x = head[idx];
				else
					x = '0;
			end
			tap = int'($signed(tap_words[k / TAPS_PER_WORD][TAP_W * (k % TAPS_PER_WORD) +: TAP_W]));
			acc += longint'(tap) * longint'(x);
		end
		// Round half up, then clip to the output width.
		rounded = (acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
		res.sat = 1'b0;
		if (rounded > (longint'(1) <<< (OUT_W - 1)) - 1) begin
			rounded = (longint'(1) <<< (OUT_W - 1)) - 1;
			res.sat = 1'b1;
		end
		if (rounded < -(longint'(1) <<< (OUT_W - 1))) begin
			rounded = -(longint'(1) <<< (OUT_W - 1));
			res.sat = 1'b1;
		end
		res.value = rounded[OUT_W-1:0];
		res.eol = eol;
		expected_results.push_back(res);
	endfunction

	// Advance the filter state by one accepted sample.
	function automatic void predict_sample(logic signed [SAMPLE_W-1:0] s, bit last);
		int cur;
		int r;
		int first;
		cur = line_pos;
		r = int'(radius_cfg);
		for (int i = WIN_LEN - 1; i > 0; i--)
			recent[i] = recent[i-1];
		recent[0] = s;
		if (cur < HEAD_LEN)
			head[cur] = s;
		if (!last) begin
			if (cur >= r)
				predict_position(cur - r, cur, 1'b0, 1'b0);
			line_pos = (cur < DEF_MAX_LINE) ? cur + 1 : DEF_MAX_LINE;
		end else begin
			first = (cur - r < 0) ? 0 : cur - r;
			for (int q = first; q <= cur; q++)
				predict_position(q, cur, 1'b1, q == cur);
			line_pos = 0;
		end
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] random_sample();
		int v;
		case ($urandom_range(5))
			0: v = 32767;
			1: v = -32768;
			2: v = int'($urandom_range(40)) - 20;
			default: v = int'($urandom);
		endcase
		return v[SAMPLE_W-1:0];
	endfunction

	task automatic queue_sample(logic signed [SAMPLE_W-1:0] s, bit last);
		line_sample_t item;
		item.sample = s;
		item.last = last;
		pending_samples.push_back(item);
	endtask

	// One register write; the mirror follows since the block is idle.
	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_RADIUS: radius_cfg = data[RADIUS_W-1:0];
			REG_BORDER: border_cfg = border_mode_t'(data[1:0]);
			REG_FILL:   fill_cfg = data[FILL_W-1:0];
			default:    tap_words[int'(idx)] = data;
		endcase
	endtask

	task automatic set_config(logic [NUM_TAP_WORDS-1:0][CFG_DATA_W-1:0] words,
			logic [CFG_DATA_W-1:0] radius, logic [CFG_DATA_W-1:0] mode,
			logic [CFG_DATA_W-1:0] fill);
		write_reg(REG_TAP_WORD_0, words[0]);
		write_reg(REG_TAP_WORD_1, words[1]);
		write_reg(REG_TAP_WORD_2, words[2]);
		write_reg(REG_TAP_WORD_3, words[3]);
		write_reg(REG_RADIUS, radius);
		write_reg(REG_BORDER, mode);
		write_reg(REG_FILL, fill);
		settings_used++;
	endtask

	// Wait until every request is taken and every result is back, then let the pipe settle.
	task automatic wait_idle();
		while (pending_samples.size() > 0 || offering || expected_results.size() > 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_idle(int sender_pct, int receiver_pct);
		sender_idle_pct = sender_pct;
		receiver_idle_pct = receiver_pct;
	endtask

	// Sample driver: presents the next pending request at the falling edge.
	always @(negedge clk) begin
		if (arst_n && !offering) begin
			if (pending_samples.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
				offered = pending_samples.pop_front();
				offering = 1'b1;
				samples_if.valid <= 1'b1;
				samples_if.sample <= offered.sample;
				samples_if.last_in_line <= offered.last;
			end else begin
				samples_if.valid <= 1'b0;
			end
		end
	end

	// Result receiver: random stalls plus one long hold-off counted here.
	always @(negedge clk) begin
		if (!arst_n) begin
			results_if.ready <= 1'b0;
		end else if (hold_left > 0) begin
			results_if.ready <= 1'b0;
			hold_left--;
		end else if (hold_wanted && !hold_done) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES - 1;
			results_if.ready <= 1'b0;
		end else begin
			results_if.ready <= ($urandom_range(99) >= receiver_idle_pct);
		end
	end

	// Monitor: predicts on each accepted sample and checks each accepted result.
	always @(posedge clk) begin : monitor
		filt_result_t want;
		if (arst_n && samples_if.valid && samples_if.ready) begin
			predict_sample(samples_if.sample, samples_if.last_in_line);
			offering = 1'b0;
			samples_sent++;
			if (samples_if.last_in_line)
				lines_sent++;
		end
		if (arst_n && results_if.valid && results_if.ready) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				report_mismatch($sformatf("result %0d arrived with nothing awaited",
					results_seen));
			end else begin
				want = expected_results.pop_front();
				if (results_if.filtered_value !== want.value)
					report_mismatch($sformatf("result %0d value %0d, wanted %0d",
						results_seen, results_if.filtered_value, want.value));
				if (results_if.saturated !== want.sat)
					report_mismatch($sformatf("result %0d saturated %b, wanted %b",
						results_seen, results_if.saturated, want.sat));
				if (results_if.end_of_line !== want.eol)
					report_mismatch($sformatf("result %0d end_of_line %b, wanted %b",
						results_seen, results_if.end_of_line, want.eol));
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results still awaited",
				cycle_count, expected_results.size());
			$display("FAIL");
			$finish;
		end
	end

	// Stimulus: directed lines, one long line, then random phases.
	initial begin
		logic [NUM_TAP_WORDS-1:0][CFG_DATA_W-1:0] words;
		logic [CFG_DATA_W-1:0] rad_data;
		logic [CFG_DATA_W-1:0] mode_data;
		logic [CFG_DATA_W-1:0] fill_data;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		samples_if.valid = 1'b0;
		samples_if.sample = '0;
		samples_if.last_in_line = 1'b0;
		results_if.ready = 1'b0;
		for (int w = 0; w < NUM_TAP_WORDS; w++)
			tap_words[w] = '0;
		radius_cfg = RADIUS_W'(1);
		border_cfg = BORDER_CONSTANT;
		fill_cfg = '0;
		for (int i = 0; i < WIN_LEN; i++)
			recent[i] = '0;
		for (int i = 0; i < HEAD_LEN; i++)
			head[i] = '0;
		line_pos = 0;
		set_idle(0, 0);
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset settings: all taps zero, so every result is zero.
		queue_sample(16'sh7FFF, 1'b0);
		queue_sample(16'sh8000, 1'b1);
		wait_idle();

		// Widest kernel, most negative taps, most negative samples but for the last: a large positive sum.
		set_config({4{64'h8000_8000_8000_8000}}, 7, BORDER_REPLICATE, 0);
		for (int i = 0; i < 7; i++)
			queue_sample(16'sh8000, 1'b0);
		queue_sample(16'sh7FFF, 1'b1);
		wait_idle();

		// Single tap of one half: rounding of halves toward plus infinity.
		set_config({64'h0, 64'h0, 64'h0, 64'h0000_0000_0000_2000}, 0, BORDER_CONSTANT,
			64'hFFFF_FFFF_FFFF_8000);
		queue_sample(16'sd1, 1'b0);
		queue_sample(-16'sd1, 1'b0);
		queue_sample(16'sd3, 1'b0);
		queue_sample(-16'sd3, 1'b1);
		wait_idle();

		// Each border mode on a short kernel with distinct taps.
		for (int m = 0; m < 4; m++) begin
			set_config({64'h0, 64'h0, 64'h0000_0000_0000_1400, 64'h1000_0C00_0800_0400},
				2, m, 64'h7FFF);
			queue_sample(16'sd100, 1'b0);
			queue_sample(-16'sd200, 1'b0);
			queue_sample(16'sd300, 1'b1);
			wait_idle();
		end

		// A line no longer than the radius: reflected indexes get clamped.
		set_config({64'h0, 64'h0, 64'h0000_F000_1400_E000, 64'h1000_C400_0800_0400},
			3, BORDER_REFLECT, 0);
		queue_sample(16'sd1000, 1'b0);
		queue_sample(-16'sd1000, 1'b1);
		wait_idle();

		// A long line under the widest reflect-101 kernel.
		set_config({64'h0, {4{16'($urandom_range(16'hFFFF))}} & 64'h00FF_00FF_00FF_00FF,
			64'h0400_FC00_0800_F800, 64'h1000_F000_2000_E000}, 7, BORDER_REFL_101, 0);
		for (int i = 0; i < LONG_LINE_LEN; i++)
			queue_sample(random_sample(), i == LONG_LINE_LEN - 1);
		wait_idle();

		// Random phases; a phase may end in the middle of a line.
		line_left = 0;
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			for (int w = 0; w < NUM_TAP_WORDS; w++) begin
				case ($urandom_range(3))
					0: words[w] = {4{16'h7FFF}};
					1: words[w] = {4{16'h8000}};
					default: words[w] = {$urandom, $urandom};
				endcase
			end
			rad_data = {$urandom, $urandom};
			rad_data[RADIUS_W-1:0] = RADIUS_W'((ph == 0) ? 0 : (ph == 1) ? 7 :
				$urandom_range(7));
			mode_data = {$urandom, $urandom};
			if (ph < 4)
				mode_data[1:0] = 2'(ph);
			fill_data = {$urandom, $urandom};
			if (ph % 3 == 0)
				fill_data[FILL_W-1:0] = (ph % 2 == 0) ? 16'h7FFF : 16'h8000;
			set_config(words, rad_data, mode_data, fill_data);
			case (ph % 4)
				0: set_idle(0, 0);
				1: set_idle(68, 0);
				2: set_idle(0, 68);
				default: set_idle(12, 12);
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (line_left == 0) begin
					if (radius_cfg > 0 && $urandom_range(99) < 8)
						line_left = $urandom_range(int'(radius_cfg), 1);
					else
						line_left = $urandom_range(int'(radius_cfg) + 24, int'(radius_cfg) + 1);
				end
				queue_sample(random_sample(), line_left == 1);
				line_left--;
			end
			// Hold the results back while samples keep coming.
			if (ph == PRESSURE_PH)
				hold_wanted = 1'b1;
			wait_idle();
		end

		repeat (20) @(negedge clk);
		$display("Checked %0d results from %0d samples in %0d lines under %0d settings.",
			results_seen, samples_sent, lines_sent, settings_used);
		$display("Covered radii 0 and 7, all border modes, short and long lines, %s",
			"mid-line setting changes and output back-pressure.");
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
